### rtl/core/ssw_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the spaced-seed word generator.
// Used by every module and interface of the block; depends on nothing else.
package ssw_pkg;

  localparam int unsigned MAX_WIDTH  = 32;
  localparam int unsigned FRAMES     = 6;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ALPHA_W    = 5;
  localparam int unsigned LETTER_W   = 5;
  localparam int unsigned FRAME_W    = 3;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned PTR_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned RING_DEPTH = FRAMES * MAX_WIDTH;
  localparam int unsigned RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned PROD_W     = WORD_W + ALPHA_W;
  localparam int unsigned DIV_CNT_W  = $clog2(PROD_W);

  localparam logic [WORD_W-1:0] PAT_MASK = WORD_W'((64'd1 << MAX_WIDTH) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] CFG_SEED_PATTERN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_PATTERN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE     = 2'd3;

  localparam logic [FUNC_W-1:0] FN_LETTER = 2'd0;
  localparam logic [FUNC_W-1:0] FN_MARK   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd2;

  typedef struct packed {
    logic [WORD_W-1:0]  pattern;
    logic [ALPHA_W-1:0] alpha;
    logic               mirror;
    logic [WORD_W-1:0]  table_size;
    logic [CNT_W-1:0]   width;
    logic [CNT_W-1:0]   weight;
    logic               continuous;
  } cfg_t;

  typedef struct packed {
    logic                clear;
    logic                we;
    logic [FRAME_W-1:0]  wr_frame;
    logic [PTR_W-1:0]    wr_idx;
    logic [LETTER_W-1:0] wr_letter;
    logic                wr_good;
    logic [FRAME_W-1:0]  rd_frame;
    logic [PTR_W-1:0]    rd_idx;
  } ring_req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   acc;
    logic [ALPHA_W-1:0]  radix;
    logic [LETTER_W-1:0] addend;
    logic [WORD_W-1:0]   rem;
    logic                shift_bit;
    logic [WORD_W-1:0]   divisor;
  } alu_in_t;

  typedef struct packed {
    logic [PROD_W-1:0] mac;
    logic [WORD_W-1:0] rem;
  } alu_out_t;

  function automatic logic [CNT_W-1:0] pat_width(input logic [WORD_W-1:0] p);
    logic [CNT_W-1:0] w;
    w = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      if (p[i]) begin
        w = CNT_W'(i + 1);
      end
    end
    return w;
  endfunction

  function automatic logic [CNT_W-1:0] pat_weight(input logic [WORD_W-1:0] p);
    logic [2:0]       nib [WORD_W/4];
    logic [CNT_W-1:0] sum;
    for (int i = 0; i < WORD_W / 4; i++) begin
      nib[i] = 3'(p[4*i]) + 3'(p[4*i+1]) + 3'(p[4*i+2]) + 3'(p[4*i+3]);
    end
    sum = '0;
    for (int i = 0; i < WORD_W / 4; i++) begin
      sum = sum + CNT_W'(nib[i]);
    end
    return sum;
  endfunction

endpackage

### rtl/core/ssw_in_if.sv
`timescale 1ns / 1ps
// Request channel of the spaced-seed word generator: valid, ready and the item fields.
// Depends on ssw_pkg.
interface ssw_in_if import ssw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [LETTER_W-1:0] letter;
  logic [FRAME_W-1:0]  frame;

  modport source (output valid, output func, output letter, output frame, input ready);
  modport sink (input valid, input func, input letter, input frame, output ready);
endinterface

### rtl/core/ssw_out_if.sv
`timescale 1ns / 1ps
// Result channel of the spaced-seed word generator: valid, ready and the word fields.
// Depends on ssw_pkg.
interface ssw_out_if import ssw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word_code;
  logic              word_valid;

  modport source (output valid, output word_code, output word_valid, input ready);
  modport sink (input valid, input word_code, input word_valid, output ready);
endinterface

### rtl/core/ssw_cfg.sv
`timescale 1ns / 1ps
// Configuration registers with the pattern width, weight and kind derived at write time.
// Depends on ssw_pkg.
module ssw_cfg import ssw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic [WORD_W-1:0] pat_masked;
  logic [WORD_W-1:0] pat_eff;
  logic [CNT_W-1:0]  new_width;
  logic [CNT_W-1:0]  new_weight;

  assign pat_masked = WORD_W'(cfg_wdata_i) & PAT_MASK;
  assign pat_eff    = (pat_masked == '0) ? WORD_W'(1) : pat_masked;
  assign new_width  = pat_width(pat_eff);
  assign new_weight = pat_weight(pat_eff);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SEED_PATTERN: begin
          cfg_d.pattern    = pat_eff;
          cfg_d.width      = new_width;
          cfg_d.weight     = new_weight;
          cfg_d.continuous = (new_width == new_weight);
        end
        CFG_ALPHABET_SIZE:  cfg_d.alpha      = cfg_wdata_i[ALPHA_W-1:0];
        CFG_MIRROR_PATTERN: cfg_d.mirror     = cfg_wdata_i[0];
        CFG_TABLE_SIZE:     cfg_d.table_size = WORD_W'(cfg_wdata_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern    <= WORD_W'(1);
      cfg_q.alpha      <= ALPHA_W'(4);
      cfg_q.mirror     <= 1'b0;
      cfg_q.table_size <= WORD_W'(256);
      cfg_q.width      <= CNT_W'(1);
      cfg_q.weight     <= CNT_W'(1);
      cfg_q.continuous <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/ssw_ring.sv
`timescale 1ns / 1ps
// Letter ring memory of all frames with one good flag per entry and a registered read port.
// Depends on ssw_pkg.
module ssw_ring import ssw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ring_req_t           req_i,
  output logic [LETTER_W-1:0] rd_letter_o,
  output logic                rd_good_o
);

  logic [LETTER_W-1:0]   mem_q [RING_DEPTH];
  logic [RING_DEPTH-1:0] good_q;
  logic [LETTER_W-1:0]   rd_letter_q;
  logic                  rd_good_q;
  logic [RING_AW-1:0]    wr_addr;
  logic [RING_AW-1:0]    rd_addr;

  assign wr_addr = RING_AW'(req_i.wr_frame) * RING_AW'(MAX_WIDTH) + RING_AW'(req_i.wr_idx);
  assign rd_addr = RING_AW'(req_i.rd_frame) * RING_AW'(MAX_WIDTH) + RING_AW'(req_i.rd_idx);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[wr_addr] <= req_i.wr_letter;
    end
    rd_letter_q <= mem_q[rd_addr];
  end

  // An entry that was never written since the last clear reads as bad.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q    <= '0;
      rd_good_q <= 1'b0;
    end else begin
      if (req_i.clear) begin
        good_q <= '0;
      end else if (req_i.we) begin
        good_q[wr_addr] <= req_i.wr_good;
      end
      rd_good_q <= good_q[rd_addr];
    end
  end

  assign rd_letter_o = rd_letter_q;
  assign rd_good_o   = rd_good_q;

endmodule

### rtl/core/ssw_alu.sv
`timescale 1ns / 1ps
// Shared arithmetic unit: radix multiply-add for word codes and one restoring remainder step.
// Depends on ssw_pkg.
module ssw_alu import ssw_pkg::*; (
  input  alu_in_t  in_i,
  output alu_out_t out_o
);

  logic [WORD_W:0] shifted;
  logic [WORD_W:0] diff;
  logic            ge;

  assign out_o.mac = PROD_W'(in_i.acc) * PROD_W'(in_i.radix) + PROD_W'(in_i.addend);

  assign shifted   = {in_i.rem, in_i.shift_bit};
  assign ge        = (shifted >= {1'b0, in_i.divisor});
  assign diff      = shifted - {1'b0, in_i.divisor};
  assign out_o.rem = ge ? diff[WORD_W-1:0] : shifted[WORD_W-1:0];

endmodule

### rtl/core/spaced_seed_word_generator_top.sv
`timescale 1ns / 1ps
// Top level of the spaced-seed word generator: sequencer, per-frame state and result register.
// Depends on ssw_pkg, ssw_in_if, ssw_out_if, ssw_cfg, ssw_ring and ssw_alu.
//
//   Channel  Dir  Handshake          Contents
//   in_i     in   valid/ready        func, letter, frame
//   out_o    out  valid/ready        word_code, word_valid
//   cfg      in   cfg_we_i           cfg_idx_i, cfg_wdata_i
//
// A spaced-pattern letter runs through a pointer fix-up, the ring write, one ring read per
// pattern position through the shared multiply-add, and a drain step. A contiguous-pattern
// letter runs the multiply-add and then the one-bit-per-cycle remainder (the multiply-add
// alone when table_size is zero); clears, ignored requests and contiguous-pattern marks go
// straight to the done state, and a spaced-pattern mark takes the pointer fix-up and ring write.
// Reset clears all frames at once; a finished result waits in the output register while
// the next request is taken, and the sequencer stalls only when a second result is ready.
module spaced_seed_word_generator_top import ssw_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  ssw_in_if.sink                in_i,
  ssw_out_if.source             out_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_DIV    = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  logic [2:0]           state_q, state_d;
  logic [FUNC_W-1:0]    func_q, func_d;
  logic [LETTER_W-1:0]  letter_q, letter_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;
  logic [PTR_W-1:0]     red_q, red_d;
  logic [PTR_W-1:0]     s_q, s_d;
  logic [PTR_W-1:0]     q_q, q_d;
  logic                 pend_q, pend_d;
  logic                 pick_q, pick_d;
  logic [WORD_W-1:0]    acc_q, acc_d;
  logic                 ok_q, ok_d;
  logic [PROD_W-1:0]    div_q, div_d;
  logic [WORD_W-1:0]    rem_q, rem_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic [WORD_W-1:0]    res_code_q, res_code_d;
  logic                 res_vld_q, res_vld_d;
  logic                 out_vld_q, out_vld_d;
  logic [WORD_W-1:0]    out_code_q, out_code_d;
  logic                 out_wv_q, out_wv_d;

  logic [PTR_W-1:0]     ring_ptr_q [FRAMES];
  logic [PTR_W-1:0]     ring_ptr_d [FRAMES];
  logic [WORD_W-1:0]    roll_q [FRAMES];
  logic [WORD_W-1:0]    roll_d [FRAMES];
  logic [WORD_W-1:0]    cd_q [FRAMES];
  logic [WORD_W-1:0]    cd_d [FRAMES];

  cfg_t                 cfg;
  ring_req_t            ring_req;
  logic [LETTER_W-1:0]  rd_letter;
  logic                 rd_good;
  alu_in_t              alu_in;
  alu_out_t             alu_out;

  logic                 in_fire;
  logic                 out_free;
  logic [WORD_W-1:0]    top_bit;
  logic [CNT_W-1:0]     ptr_step;
  logic [PTR_W-1:0]     ptr_next;
  logic                 red_ge;
  logic [CNT_W-1:0]     red_diff;
  logic [CNT_W-1:0]     pos_full;
  logic [CNT_W-1:0]     q_inc;
  logic [PTR_W-1:0]     q_next;
  logic                 s_last;
  logic                 take;
  logic                 ok_upd;
  logic [WORD_W-1:0]    acc_upd;
  logic [WORD_W-1:0]    cd_shift;
  logic                 cd_zero;

  ssw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssw_ring u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (ring_req),
    .rd_letter_o (rd_letter),
    .rd_good_o   (rd_good)
  );

  ssw_alu u_alu (
    .in_i  (alu_in),
    .out_o (alu_out)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;

  assign top_bit  = WORD_W'(1) << (cfg.weight - CNT_W'(1));
  assign ptr_step = CNT_W'(ring_ptr_q[frame_q]) + CNT_W'(1);
  assign ptr_next = (ptr_step >= cfg.width) ? '0 : ptr_step[PTR_W-1:0];
  assign red_ge   = (CNT_W'(red_q) >= cfg.width);
  assign red_diff = CNT_W'(red_q) - cfg.width;
  assign pos_full = cfg.mirror ? (cfg.width - CNT_W'(1) - CNT_W'(s_q)) : CNT_W'(s_q);
  assign q_inc    = CNT_W'(q_q) + CNT_W'(1);
  assign q_next   = (q_inc == cfg.width) ? '0 : q_inc[PTR_W-1:0];
  assign s_last   = (CNT_W'(s_q) + CNT_W'(1) == cfg.width);

  assign take     = pend_q && pick_q;
  assign ok_upd   = ok_q && !(take && !rd_good);
  assign acc_upd  = take ? alu_out.mac[WORD_W-1:0] : acc_q;
  assign cd_shift = cd_q[frame_q] >> 1;
  assign cd_zero  = (cd_shift == '0);

  always_comb begin
    alu_in.acc       = (state_q == ST_MUL) ? roll_q[frame_q] : acc_q;
    alu_in.radix     = cfg.alpha;
    alu_in.addend    = (state_q == ST_MUL) ? letter_q : rd_letter;
    alu_in.rem       = rem_q;
    alu_in.shift_bit = div_q[PROD_W-1];
    alu_in.divisor   = cfg.table_size;
  end

  always_comb begin
    state_d    = state_q;
    func_d     = func_q;
    letter_d   = letter_q;
    frame_d    = frame_q;
    red_d      = red_q;
    s_d        = s_q;
    q_d        = q_q;
    pend_d     = pend_q;
    pick_d     = pick_q;
    acc_d      = acc_q;
    ok_d       = ok_q;
    div_d      = div_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    res_code_d = res_code_q;
    res_vld_d  = res_vld_q;
    out_vld_d  = out_vld_q;
    out_code_d = out_code_q;
    out_wv_d   = out_wv_q;
    ring_ptr_d = ring_ptr_q;
    roll_d     = roll_q;
    cd_d       = cd_q;

    ring_req.clear     = 1'b0;
    ring_req.we        = 1'b0;
    ring_req.wr_frame  = frame_q;
    ring_req.wr_idx    = red_q;
    ring_req.wr_letter = letter_q;
    ring_req.wr_good   = (func_q == FN_LETTER);
    ring_req.rd_frame  = frame_q;
    ring_req.rd_idx    = q_q;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          func_d     = in_i.func;
          letter_d   = in_i.letter;
          frame_d    = in_i.frame;
          res_code_d = '0;
          res_vld_d  = 1'b0;
          priority if (in_i.func == FN_CLEAR) begin
            ring_req.clear = 1'b1;
            for (int f = 0; f < FRAMES; f++) begin
              ring_ptr_d[f] = '0;
              roll_d[f]     = '0;
              cd_d[f]       = top_bit;
            end
            state_d = ST_DONE;
          end else if ((in_i.func != FN_LETTER && in_i.func != FN_MARK) ||
                       in_i.frame >= FRAME_W'(FRAMES)) begin
            state_d = ST_DONE;
          end else if (cfg.continuous) begin
            if (in_i.func == FN_MARK) begin
              roll_d[in_i.frame] = '0;
              cd_d[in_i.frame]   = top_bit;
              state_d            = ST_DONE;
            end else begin
              state_d = ST_MUL;
            end
          end else begin
            red_d   = ring_ptr_q[in_i.frame];
            state_d = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (red_ge) begin
          red_d = red_diff[PTR_W-1:0];
        end else begin
          ring_req.we         = 1'b1;
          ring_ptr_d[frame_q] = ptr_next;
          if (func_q == FN_MARK) begin
            state_d = ST_DONE;
          end else begin
            q_d     = ptr_next;
            s_d     = '0;
            acc_d   = '0;
            ok_d    = 1'b1;
            pend_d  = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        acc_d  = acc_upd;
        ok_d   = ok_upd;
        pend_d = 1'b1;
        pick_d = cfg.pattern[pos_full[PTR_W-1:0]];
        s_d    = s_q + PTR_W'(1);
        q_d    = q_next;
        if (s_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        pend_d           = 1'b0;
        res_vld_d        = ok_upd;
        res_code_d       = ok_upd ? acc_upd : '0;
        cd_d[frame_q]    = ok_upd ? '0 : WORD_W'(1);
        state_d          = ST_DONE;
      end
      ST_MUL: begin
        if (cfg.table_size == '0) begin
          roll_d[frame_q] = alu_out.mac[WORD_W-1:0];
          cd_d[frame_q]   = cd_shift;
          res_vld_d       = cd_zero;
          res_code_d      = cd_zero ? alu_out.mac[WORD_W-1:0] : '0;
          state_d         = ST_DONE;
        end else begin
          div_d   = alu_out.mac;
          rem_d   = '0;
          dcnt_d  = DIV_CNT_W'(PROD_W - 1);
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = alu_out.rem;
        div_d  = div_q << 1;
        dcnt_d = dcnt_q - DIV_CNT_W'(1);
        if (dcnt_q == '0) begin
          roll_d[frame_q] = alu_out.rem;
          cd_d[frame_q]   = cd_shift;
          res_vld_d       = cd_zero;
          res_code_d      = cd_zero ? alu_out.rem : '0;
          state_d         = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_vld_d  = 1'b1;
          out_code_d = res_code_q;
          out_wv_d   = res_vld_q;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      for (int f = 0; f < FRAMES; f++) begin
        ring_ptr_q[f] <= '0;
        roll_q[f]     <= '0;
        cd_q[f]       <= WORD_W'(1);
      end
    end else begin
      state_q    <= state_d;
      out_vld_q  <= out_vld_d;
      pend_q     <= pend_d;
      ring_ptr_q <= ring_ptr_d;
      roll_q     <= roll_d;
      cd_q       <= cd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    letter_q   <= letter_d;
    frame_q    <= frame_d;
    red_q      <= red_d;
    s_q        <= s_d;
    q_q        <= q_d;
    pick_q     <= pick_d;
    acc_q      <= acc_d;
    ok_q       <= ok_d;
    div_q      <= div_d;
    rem_q      <= rem_d;
    dcnt_q     <= dcnt_d;
    res_code_q <= res_code_d;
    res_vld_q  <= res_vld_d;
    out_code_q <= out_code_d;
    out_wv_q   <= out_wv_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.word_code  = out_code_q;
  assign out_o.word_valid = out_wv_q;

  a_ring_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_req.we |-> (CNT_W'(ring_req.wr_idx) < cfg.width))
    else $error("Ring write beyond the pattern width.");

  a_pointer_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE && ring_req.we) |=> (CNT_W'(ring_ptr_q[frame_q]) < cfg.width))
    else $error("Ring pointer left the pattern width after a step.");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (CNT_W'(s_q) < cfg.width && CNT_W'(q_q) < cfg.width))
    else $error("Scan position beyond the pattern width.");

  a_remainder_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < cfg.table_size))
    else $error("Partial remainder not below the table size.");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == ST_DONE))
    else $error("Result register loaded outside the done state.");

endmodule
